/* sv/swd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swd_pkg
// Types and constants shared by the stream word deleter modules.
// ----------------------------------------------------------------------------
package swd_pkg;

    // Capacity of the pattern registers and of the pending store.
    localparam int PAT_STORE  = 32;
    localparam int CNT_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_W      = 8 * PAT_STORE;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PAT_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       run_last;
        logic       output_done;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic load;    // append the accepted byte to the pending store
        logic emit;    // load the output register
        logic marker;  // the emitted transfer is the empty end marker
        logic pop;     // drop the front pending byte
        logic clear;   // empty the pending store
        logic last;
        logic done;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic cnt_zero;
        logic cnt_one;
        logic pre_now;     // pending bytes form a prefix of the pattern
        logic match_now;   // pending count equals the pattern length
        logic pre_next;    // prefix once the front byte is dropped
        logic match_next;  // count after the drop equals the pattern length
        logic stream_end;  // latched end flag of the current byte
        logic out_free;    // output register can take a transfer
    } t_status;

endpackage
`default_nettype wire

/* sv/swd_stream_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swd_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface swd_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* sv/swd_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swd_ctrl
// Sequencer: takes a byte, scans the pending store one step per cycle while the
// output register is free, and flushes it at the end of a stream.
// ----------------------------------------------------------------------------
module swd_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  swd_pkg::t_status i_status,
    output swd_pkg::t_cmd    o_cmd
);
    import swd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_emitted, n_emitted;
    logic   stop_after_pop;
    logic   rem_zero;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state        = r_state;
        n_emitted      = r_emitted;
        o_cmd          = '0;
        // After dropping the front byte the scan stops if the rest is a prefix;
        // a full match at that point empties the store as well.
        stop_after_pop = i_status.pre_next;
        rem_zero       = i_status.cnt_one || (i_status.pre_next && i_status.match_next);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_emitted  = 1'b0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.pre_now) begin
                    if (!i_status.stream_end) begin
                        o_cmd.clear = i_status.match_now;
                        n_state     = ST_IDLE;
                    end else if (!(i_status.match_now || i_status.cnt_zero)) begin
                        n_state = ST_FLUSH;
                    end else if (r_emitted) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end else if (i_status.out_free) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.marker = 1'b1;
                        o_cmd.last   = 1'b1;
                        o_cmd.done   = 1'b1;
                        o_cmd.clear  = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.pop  = 1'b1;
                    o_cmd.last = stop_after_pop && (!i_status.stream_end || rem_zero);
                    o_cmd.done = o_cmd.last && i_status.stream_end;
                    n_emitted  = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.pop  = 1'b1;
                    o_cmd.last = i_status.cnt_one;
                    o_cmd.done = i_status.cnt_one;
                    if (i_status.cnt_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_emitted <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_emitted <= n_emitted;
        end
    end

endmodule
`default_nettype wire

/* sv/swd_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swd_datapath
// Pattern registers, pending byte shift store with prefix comparators, and
// the output register.
// ----------------------------------------------------------------------------
module swd_datapath #(
    parameter int MAX_PATTERN = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire  [swd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [swd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  swd_pkg::t_in_item                   i_in_item,
    input  swd_pkg::t_cmd                       i_cmd,
    input  wire                                 i_out_ready,
    output swd_pkg::t_status                    o_status,
    output logic                                o_out_valid,
    output swd_pkg::t_out_item                  o_out_item
);
    import swd_pkg::*;

    localparam int DEPTH = (MAX_PATTERN < PAT_STORE) ? MAX_PATTERN : PAT_STORE;
    localparam logic [CNT_W-1:0] LEN_LIMIT = CNT_W'(DEPTH);

    logic [PAT_W-1:0]  r_pat;
    logic [CNT_W-1:0]  r_len;
    logic [7:0]        r_pend [DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic              r_end;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [CNT_W-1:0]  eff_len;
    logic [CNT_W-1:0]  cnt_less;
    logic [DEPTH-1:0]  ok_now;
    logic [DEPTH-1:0]  ok_next;
    logic              out_free;

    // Length 0 behaves as 1; anything above the store is clamped.
    always_comb begin
        eff_len = r_len;
        if (eff_len == '0) begin
            eff_len = CNT_W'(1);
        end
        if (eff_len > LEN_LIMIT) begin
            eff_len = LEN_LIMIT;
        end
    end

    assign cnt_less = r_count - CNT_W'(1);

    // Each entry is compared against its own pattern byte and, for the
    // lookahead, the next entry against it as well.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ok_now[i] = (r_pend[i] == r_pat[8*i +: 8]) || (CNT_W'(i) >= r_count);
            if (i < DEPTH - 1) begin
                ok_next[i] = (r_pend[(i < DEPTH - 1) ? i + 1 : i] == r_pat[8*i +: 8])
                             || (CNT_W'(i) >= cnt_less);
            end else begin
                ok_next[i] = 1'b1;
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status            = '0;
        o_status.cnt_zero   = (r_count == '0);
        o_status.cnt_one    = (r_count == CNT_W'(1));
        o_status.pre_now    = (r_count <= eff_len) && (&ok_now);
        o_status.match_now  = (r_count == eff_len);
        o_status.pre_next   = (cnt_less <= eff_len) && (&ok_next);
        o_status.match_next = (cnt_less == eff_len);
        o_status.stream_end = r_end;
        o_status.out_free   = out_free;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= '0;
            r_len <= CNT_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_PAT_0_7:   r_pat[0*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                REG_PAT_8_15:  r_pat[1*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                REG_PAT_16_23: r_pat[2*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                REG_PAT_24_31: r_pat[3*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                REG_PAT_LEN:   r_len <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pending store: written at the fill position, shifted on a drop.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_cmd.load && (r_count == CNT_W'(i))) begin
                r_pend[i] <= i_in_item.text_byte;
            end else if (i_cmd.pop && (i < DEPTH - 1)) begin
                r_pend[i] <= r_pend[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_end   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_count <= r_count + CNT_W'(1);
                r_end   <= i_in_item.stream_end;
            end else if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.pop) begin
                r_count <= cnt_less;
            end
        end
    end

    // Output register: a new transfer may be loaded while the old one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_byte     <= i_cmd.marker ? 8'd0 : r_pend[0];
            r_out.byte_present <= !i_cmd.marker;
            r_out.run_last     <= i_cmd.last;
            r_out.output_done  <= i_cmd.done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

/* sv/stream_word_deleter_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stream_word_deleter_top
// Copies a byte stream with every leftmost, non-overlapping pattern match
// removed.
// ----------------------------------------------------------------------------
// A byte is taken while the block is idle and examined in the scan that
// follows: the pending store drops one byte from its front per cycle while
// the output register is free and waits while the output side stalls; no
// new byte is taken until the scan has settled. Bytes that still form a
// prefix of the pattern are held back; a full match is discarded, and a
// byte marked as the end of the stream flushes what is held, or gives an
// empty end marker when that byte released nothing. Write the pattern
// registers only while the block is idle.
// ----------------------------------------------------------------------------
module stream_word_deleter_top #(
    parameter int MAX_PATTERN = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wr_en,
    input  wire  [swd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [swd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    swd_stream_if.sink                       i_in,
    swd_stream_if.source                     o_out
);
    import swd_pkg::*;

    t_cmd      cmd;
    t_status   status;
    t_out_item out_item;
    logic      out_valid;
    logic      in_ready;

    swd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    swd_datapath #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in.payload),
        .i_cmd       (cmd),
        .i_out_ready (o_out.ready),
        .o_status    (status),
        .o_out_valid (out_valid),
        .o_out_item  (out_item)
    );

    assign i_in.ready    = in_ready;
    assign o_out.valid   = out_valid;
    assign o_out.payload = out_item;

endmodule
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks stream_word_deleter_top against a cycle-free model of pattern removal.
// A short plan of directed rows comes first: reset values, single-byte and
// empty-marker streams, full and broken matches, a pattern that changes while
// bytes are held back, and out-of-range lengths. Random phases follow, each
// with a fresh pattern and length. Every output transfer is compared field by
// field with the oldest predicted result.
// ----------------------------------------------------------------------------
module testbench;
    import swd_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int MAX_PATTERN   = 32;
    localparam int RANDOM_ITEMS  = 88;
    localparam int QUIET_AFTER   = 68;
    localparam int DRAIN_CYCLES  = 8;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_C = 8'h63;
    localparam logic [7:0] CH_X = 8'h78;
    localparam logic [7:0] CH_Z = 8'h7a;

    typedef enum logic [1:0] {ROW_CFG, ROW_TEXT, ROW_KNOWN} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  value;      // register data, or the text byte in bits 7:0
        logic                   stream_end;
        t_out_item              due;
    } t_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    swd_stream_if #(.t_payload(t_in_item))  text_if ();
    swd_stream_if #(.t_payload(t_out_item)) kept_if ();

    stream_word_deleter_top #(.MAX_PATTERN(MAX_PATTERN)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (text_if),
        .o_out       (kept_if)
    );

    // Model state: held-back bytes and the pattern registers.
    logic [7:0]            held [0:PAT_STORE];
    int unsigned           held_n;
    logic [CFG_DATA_W-1:0] pat_word [0:3];
    logic [CNT_W-1:0]      pat_len;

    t_out_item   step_q [$];
    t_out_item   kept_q [$];
    t_row        plan [$];

    bit          idle_on;
    int unsigned stall_left;
    int unsigned text_sent;
    int unsigned directed_sent;
    int unsigned random_sent;
    int unsigned settings_n;
    int unsigned results_seen;
    int unsigned mismatches;
    t_out_item   seen_item;
    t_out_item   due_item;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------
    function automatic int unsigned pat_span();
        int unsigned n;
        n = pat_len;
        if (n < 1) n = 1;
        if (n > PAT_STORE) n = PAT_STORE;
        if (n > MAX_PATTERN) n = MAX_PATTERN;
        return n;
    endfunction

    function automatic logic [7:0] pat_at(int unsigned i);
        return pat_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function automatic bit held_is_prefix();
        if (held_n > pat_span()) return 1'b0;
        for (int i = 0; i < held_n; i++)
            if (held[i] != pat_at(i)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void emit_front();
        step_q.push_back('{held[0], 1'b1, 1'b0, 1'b0});
        for (int i = 1; i < held_n; i++)
            held[i - 1] = held[i];
        if (held_n > 0) held_n--;
    endfunction

    function automatic void predict_kept_bytes(logic [7:0] b, logic e);
        t_out_item tail;
        step_q.delete();
        if (held_n >= PAT_STORE) emit_front();
        held[held_n] = b;
        held_n++;
        // Drop a completed match, or shed bytes from the front until the rest
        // is a prefix of the pattern again.
        while (held_n > 0) begin
            if (held_is_prefix()) begin
                if (held_n == pat_span()) held_n = 0;
                break;
            end
            emit_front();
        end
        if (e) begin
            for (int i = 0; i < held_n; i++)
                step_q.push_back('{held[i], 1'b1, 1'b0, 1'b0});
            held_n = 0;
            if (step_q.size() == 0) step_q.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
            tail = step_q.pop_back();
            tail.output_done = 1'b1;
            step_q.push_back(tail);
        end
        if (step_q.size() > 0) begin
            tail = step_q.pop_back();
            tail.run_last = 1'b1;
            step_q.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] alpha_byte(bit narrow);
        if (narrow) return CH_A + 8'($urandom_range(0, 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rnd_word(bit narrow);
        logic [CFG_DATA_W-1:0] w;
        for (int k = 0; k < 8; k++)
            w[k * 8 +: 8] = alpha_byte(narrow);
        return w;
    endfunction

    function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        plan.push_back('{ROW_CFG, idx, v, 1'b0, '0});
    endfunction

    function automatic void row_text(logic [7:0] b, logic e);
        plan.push_back('{ROW_TEXT, '0, {56'h0, b}, e, '0});
    endfunction

    function automatic void row_known(logic [7:0] b, logic e, logic [7:0] ob, logic op,
                                      logic od);
        plan.push_back('{ROW_KNOWN, '0, {56'h0, b}, e, '{ob, op, 1'b1, od}});
    endfunction

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == REG_PAT_LEN) begin
            pat_len = data[CNT_W-1:0];
            settings_n++;
        end else if (idx <= REG_PAT_24_31) begin
            pat_word[idx[1:0]] = data;
        end
    endtask

    task automatic wait_idle();
        text_if.valid <= 1'b0;
        while (kept_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_text(logic [7:0] b, logic e, bit known, t_out_item due);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            text_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        text_if.valid   <= 1'b1;
        text_if.payload <= '{text_byte: b, stream_end: e};
        @(posedge i_clk);
        while (!text_if.ready) @(posedge i_clk);
        predict_kept_bytes(b, e);
        if (known) begin
            kept_q.push_back(due);
        end else begin
            foreach (step_q[i]) kept_q.push_back(step_q[i]);
        end
        text_sent++;
    endtask

    task automatic feed(logic [7:0] b);
        push_text(b, $urandom_range(0, 11) == 0, 1'b0, '0);
        random_sent++;
        if (random_sent >= QUIET_AFTER) idle_on = 1'b0;
    endtask

    task automatic apply_pattern(logic [CNT_W-1:0] len_code, bit narrow);
        wait_idle();
        cfg_write(REG_PAT_0_7, rnd_word(narrow));
        cfg_write(REG_PAT_8_15, rnd_word(narrow));
        cfg_write(REG_PAT_16_23, rnd_word(narrow));
        cfg_write(REG_PAT_24_31, rnd_word(narrow));
        if ($urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, {$urandom, $urandom});
        cfg_write(REG_PAT_LEN, {58'h0, len_code});
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CNT_W-1:0] phase_len(int unsigned ph);
        case (ph % 8)
            0:       return 6'd3;
            1:       return 6'd40;
            2:       return 6'd0;
            3:       return 6'd32;
            4:       return 6'd2;
            5:       return 6'd1;
            6:       return 6'd5;
            default: return 6'd4;
        endcase
    endfunction

    function automatic void note_mismatch(string what, t_out_item due, t_out_item seen);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected byte %02h present %b last %b done %b,",
                     $time, what, due.out_byte, due.byte_present, due.run_last,
                     due.output_done,
                     " got byte %02h present %b last %b done %b",
                     seen.out_byte, seen.byte_present, seen.run_last, seen.output_done);
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls and checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left    <= 0;
            kept_if.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 18);
            kept_if.ready <= 1'b0;
        end else begin
            kept_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && kept_if.valid && kept_if.ready) begin
            seen_item = kept_if.payload;
            results_seen++;
            if (kept_q.size() == 0) begin
                note_mismatch("unexpected transfer", '0, seen_item);
            end else begin
                due_item = kept_q.pop_front();
                if (seen_item.out_byte !== due_item.out_byte
                        || seen_item.byte_present !== due_item.byte_present
                        || seen_item.run_last !== due_item.run_last
                        || seen_item.output_done !== due_item.output_done)
                    note_mismatch("wrong transfer", due_item, seen_item);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        bit          cfg_open;
        bit          narrow;
        int unsigned ph;
        int unsigned span;
        int unsigned quota;
        int unsigned cut;

        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        text_if.valid   = 1'b0;
        text_if.payload = '0;
        idle_on         = 1'b1;
        held_n          = 0;
        pat_len         = 6'd1;
        for (int w = 0; w < 4; w++) pat_word[w] = '0;
        for (int i = 0; i <= PAT_STORE; i++) held[i] = 8'h00;

        // Reset pattern is a single zero byte.
        row_known(8'h41, 1'b1, 8'h41, 1'b1, 1'b1);
        row_known(8'h00, 1'b1, 8'h00, 1'b0, 1'b1);
        row_known(8'hff, 1'b0, 8'hff, 1'b1, 1'b0);
        row_cfg(REG_PAT_0_7, {40'h0, CH_C, CH_B, CH_A});
        row_cfg(REG_UNUSED, {CFG_DATA_W{1'b1}});
        row_cfg(REG_PAT_LEN, 64'd3);
        row_text(CH_A, 1'b0);
        row_text(CH_B, 1'b0);
        row_text(CH_C, 1'b0);
        row_known(CH_X, 1'b0, CH_X, 1'b1, 1'b0);
        row_text(CH_A, 1'b0);
        row_text(CH_B, 1'b0);
        row_text(CH_X, 1'b0);
        row_text(CH_A, 1'b0);
        row_text(CH_A, 1'b0);
        row_text(CH_B, 1'b0);
        row_text(CH_C, 1'b0);
        row_known(CH_A, 1'b1, CH_A, 1'b1, 1'b1);
        // Shorten the pattern while two bytes are held back.
        row_text(CH_A, 1'b0);
        row_text(CH_B, 1'b0);
        row_cfg(REG_PAT_LEN, 64'd1);
        row_text(CH_Z, 1'b1);
        // A length of zero behaves as one.
        row_cfg(REG_PAT_LEN, 64'd0);
        row_known(CH_A, 1'b1, 8'h00, 1'b0, 1'b1);
        // An oversized length is clamped to the store size.
        row_cfg(REG_PAT_0_7, {CFG_DATA_W{1'b1}});
        row_cfg(REG_PAT_8_15, {CFG_DATA_W{1'b1}});
        row_cfg(REG_PAT_16_23, {CFG_DATA_W{1'b1}});
        row_cfg(REG_PAT_24_31, {CFG_DATA_W{1'b1}});
        row_cfg(REG_PAT_LEN, 64'd63);
        row_text(8'hff, 1'b0);
        row_text(8'hff, 1'b0);
        row_text(8'h00, 1'b1);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cfg_open = 1'b0;
        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                if (!cfg_open) wait_idle();
                cfg_write(plan[r].reg_idx, plan[r].value);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) i_cfg_wr_en <= 1'b0;
                cfg_open = 1'b0;
                push_text(plan[r].value[7:0], plan[r].stream_end,
                          plan[r].kind == ROW_KNOWN, plan[r].due);
                directed_sent++;
            end
        end

        // Random phases: mostly whole or broken copies of the pattern, so that
        // the held-back store fills and empties, with some stray bytes between.
        ph = 0;
        while (random_sent < RANDOM_ITEMS) begin
            narrow = $urandom_range(0, 2) != 0;
            apply_pattern(phase_len(ph), narrow);
            span  = pat_span();
            quota = random_sent + (span > 8 ? 24 : 10);
            while (random_sent < quota) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        for (int i = 0; i < span; i++) feed(pat_at(i));
                    end
                    4, 5: begin
                        cut = $urandom_range(0, span - 1);
                        for (int i = 0; i < cut; i++) feed(pat_at(i));
                        feed(alpha_byte(narrow));
                    end
                    6, 7:    feed(8'($urandom_range(0, 255)));
                    default: feed(alpha_byte(narrow));
                endcase
            end
            ph++;
        end

        wait_idle();
        $display("Sent %0d text transfers (%0d directed) under %0d pattern length settings.",
                 text_sent, directed_sent, settings_n);
        $display("Checked %0d output transfers, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("stream_word_deleter_top verification clean");
        end else begin
            $display("stream_word_deleter_top verification failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d results still outstanding.", kept_q.size());
        $display("stream_word_deleter_top verification failed");
        $finish;
    end

endmodule
